@@ src/rbq_pkg.sv @@
// ---------------------------------------------------------------------------
// rbq_pkg
// Shared field widths, request and status codes, and the result beat type
// of the ring buffer integer queue.
// ---------------------------------------------------------------------------
`default_nettype none

package rbq_pkg;

  localparam int KIND_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FIDX_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ENQ    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // one result beat
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [FIDX_W-1:0]   found_index;
    logic [DATA_W-1:0]   data_out;
    logic [STATUS_W-1:0] status;
  } out_beat_t;

endpackage

`default_nettype wire

@@ src/rbq_ram.sv @@
// ---------------------------------------------------------------------------
// rbq_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module rbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ src/ring_buffer_int_queue_top.sv @@
// ---------------------------------------------------------------------------
// ring_buffer_int_queue_top
// Circular FIFO of signed 32-bit words with enqueue, dequeue, peek, clear
// and search requests; a sequencer walks the storage RAM for search.
// ---------------------------------------------------------------------------
// Result path: enqueue, clear, unknown kinds and requests refused on a full or empty
//   queue register their result from the input beat; dequeue and peek pass through
//   the registered RAM read and S_READ; search compares the entries in S_SCAN.
// Throughput: one request at a time; a new beat is taken once the sequencer
//   is idle and the result register is empty or being drained.
// Reset: rst_n (synchronous, active low) empties the queue and sets the
//   capacity to 16; storage contents are not cleared.
`default_nettype none

module ring_buffer_int_queue_top
  import rbq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: capacity
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,   // [4:0] capacity
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // [31:0] value
  input  wire logic [2:0]  in_tuser,    // [2:0] kind
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,   // [31:0] data_out, [35:32] found_index,
                                        // [40:36] count, [47:41] zero
  output logic [1:0]       out_tuser    // [1:0] status
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [PW-1:0]     head_r, head_nxt;
  logic [PW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [PW-1:0]     scan_addr_r, scan_addr_nxt;
  logic [PW-1:0]     cmp_addr_r, cmp_addr_nxt;
  logic [CW-1:0]     issued_r, issued_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  out_beat_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [CW-1:0]     cap_eff;
  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] value;

  logic              ram_we;
  logic [PW-1:0]     ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;

  // next index around the active region
  function automatic logic [PW-1:0] adv(input logic [PW-1:0] idx,
                                        input logic [CW-1:0] cap);
    logic [CW-1:0] inc;
    inc = CW'(idx) + CW'(1);
    return (inc >= cap) ? '0 : PW'(inc);
  endfunction

  assign kind     = in_tuser;
  assign value    = in_tdata;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_tvalid && in_tready;

  // effective capacity: zero acts as one, clipped to DEPTH
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_r) > 32'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_r);
    end
  end

  // storage
  assign ram_we      = in_fire && (kind == KIND_ENQ) && (occ_r < cap_eff);
  assign ram_rd_addr = (state_r == S_SCAN) ? scan_addr_r : head_r;

  rbq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (tail_r),
    .wr_data (value),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // sequencer and pointer update
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    scan_addr_nxt = scan_addr_r;
    cmp_addr_nxt  = cmp_addr_r;
    issued_nxt    = issued_r;
    key_nxt       = key_r;
    out_load      = 1'b0;
    out_nxt       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (kind)
            KIND_ENQ: begin
              out_load = 1'b1;
              if (occ_r >= cap_eff) begin
                out_nxt.status = ST_FULL;
                out_nxt.count  = COUNT_W'(occ_r);
              end else begin
                tail_nxt       = adv(tail_r, cap_eff);
                occ_nxt        = occ_r + CW'(1);
                out_nxt.count  = COUNT_W'(occ_r + CW'(1));
              end
            end
            KIND_DEQ, KIND_PEEK: begin
              if (occ_r == '0) begin
                out_load       = 1'b1;
                out_nxt.status = ST_EMPTY;
              end else begin
                // RAM read of head is under way; S_READ loads the word into the result
                state_nxt = S_READ;
                if (kind == KIND_DEQ) begin
                  head_nxt = adv(head_r, cap_eff);
                  occ_nxt  = occ_r - CW'(1);
                end
              end
            end
            KIND_CLEAR: begin
              out_load = 1'b1;
              head_nxt = '0;
              tail_nxt = '0;
              occ_nxt  = '0;
            end
            KIND_SEARCH: begin
              if (occ_r == '0) begin
                out_load       = 1'b1;
                out_nxt.status = ST_NOTFOUND;
              end else begin
                // head is read now; next address queued behind it
                state_nxt     = S_SCAN;
                key_nxt       = value;
                cmp_addr_nxt  = head_r;
                scan_addr_nxt = adv(head_r, cap_eff);
                issued_nxt    = CW'(1);
              end
            end
            default: begin
              out_load      = 1'b1;
              out_nxt.count = COUNT_W'(occ_r);
            end
          endcase
        end
      end
      S_READ: begin
        out_load         = 1'b1;
        out_nxt.data_out = ram_rd_data;
        out_nxt.count    = COUNT_W'(occ_r);
        state_nxt        = S_IDLE;
      end
      S_SCAN: begin
        // shared compare: RAM word of cmp_addr against the key
        if (ram_rd_data == key_r) begin
          out_load            = 1'b1;
          out_nxt.found_index = FIDX_W'(cmp_addr_r);
          out_nxt.count       = COUNT_W'(occ_r);
          state_nxt           = S_IDLE;
        end else if (issued_r == occ_r) begin
          out_load       = 1'b1;
          out_nxt.status = ST_NOTFOUND;
          out_nxt.count  = COUNT_W'(occ_r);
          state_nxt      = S_IDLE;
        end else begin
          cmp_addr_nxt  = scan_addr_r;
          scan_addr_nxt = adv(scan_addr_r, cap_eff);
          issued_nxt    = issued_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers; a capacity write empties the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r  <= cfg_wdata;
        head_r <= '0;
        tail_r <= '0;
        occ_r  <= '0;
      end else begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        occ_r  <= occ_nxt;
      end
    end
  end

  // scan and payload registers
  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    cmp_addr_r  <= cmp_addr_nxt;
    issued_r    <= issued_nxt;
    key_r       <= key_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {7'd0, out_r.count, out_r.found_index, out_r.data_out};

endmodule

`default_nettype wire
